@@ rtl/dfpa_pkg.sv @@
// Shared types and constants of the decimal fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package dfpa_pkg;
   localparam int DEF_LIMBS      = 4;
   localparam int DEF_FRAC_LIMBS = 2;
   localparam int MAX_LIMBS      = 4;
   localparam int NUM_COLS       = 2 * MAX_LIMBS;
   localparam int LIMB_W         = 30;

   typedef logic [LIMB_W-1:0] limb_type;

   localparam limb_type LIMB_MAX = 30'd999999999;
   localparam limb_type BASE     = 30'd1000000000;
   // floor(2**61 / 1e9), used to estimate a quotient by the base.
   localparam logic [31:0] RECIP_BASE = 32'd2305843009;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_CMP = 2'd3
   } kind_type;

   localparam logic [1:0] ORD_EQ = 2'b00;
   localparam logic [1:0] ORD_GT = 2'b01;
   localparam logic [1:0] ORD_LT = 2'b11;

   typedef struct packed {
      kind_type                   kind;
      logic                       rn;
      logic [1:0]                 ord;
      limb_type [MAX_LIMBS-1:0]   asr;
      logic                       aovf;
   } ctl_type;
endpackage
`default_nettype wire

@@ rtl/dfpa_ifs.sv @@
// Request and response channel interfaces of the decimal fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
interface dfpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        a_negative;
   logic [29:0] a_limb3;
   logic [29:0] a_limb2;
   logic [29:0] a_limb1;
   logic [29:0] a_limb0;
   logic        b_negative;
   logic [29:0] b_limb3;
   logic [29:0] b_limb2;
   logic [29:0] b_limb1;
   logic [29:0] b_limb0;
   modport source (output valid, kind, a_negative, a_limb3, a_limb2, a_limb1, a_limb0,
                   b_negative, b_limb3, b_limb2, b_limb1, b_limb0, input ready);
   modport sink (input valid, kind, a_negative, a_limb3, a_limb2, a_limb1, a_limb0,
                 b_negative, b_limb3, b_limb2, b_limb1, b_limb0, output ready);
endinterface

interface dfpa_rsp_if;
   logic        valid;
   logic        ready;
   logic        r_negative;
   logic [29:0] r_limb3;
   logic [29:0] r_limb2;
   logic [29:0] r_limb1;
   logic [29:0] r_limb0;
   logic        overflow;
   logic [1:0]  order;
   modport source (output valid, r_negative, r_limb3, r_limb2, r_limb1, r_limb0,
                   overflow, order, input ready);
   modport sink (input valid, r_negative, r_limb3, r_limb2, r_limb1, r_limb0,
                 overflow, order, output ready);
endinterface
`default_nettype wire

@@ rtl/decimal_fixed_point_alu.sv @@
// Top level of the sign-magnitude base-1e9 fixed-point decimal ALU.
`timescale 1ns / 1ps
`default_nettype none
// Sign-magnitude decimal ALU on LIMBS base-1e9 limbs, the lowest FRAC_LIMBS of them
// fractional. Each request carries two operands and an operation (add, subtract,
// multiply, compare) and yields one response. The pipeline is eight register stages
// deep, and one request is taken every cycle when nothing stalls; the multiply path
// (product, quotient estimate, remainder correction, column sums, carry ripple) sets
// that depth. Each stage holds its item on a stall while empty stages ahead of it
// keep filling.
module decimal_fixed_point_alu #(
   parameter int LIMBS      = dfpa_pkg::DEF_LIMBS,
   parameter int FRAC_LIMBS = dfpa_pkg::DEF_FRAC_LIMBS
) (
   input wire logic   clock,
   input wire logic   reset,
   dfpa_req_if.sink   req_chan,
   dfpa_rsp_if.source rsp_chan
);
   localparam int NS = 8;
   localparam int NL = dfpa_pkg::MAX_LIMBS;
   localparam int NC = dfpa_pkg::NUM_COLS;

   logic [NS:1]   v_ff, v_in;
   logic [NS+1:1] rdy;
   logic [NS:1]   en;

   always_comb begin
      rdy[NS+1] = rsp_chan.ready;
      for (int k = NS; k >= 1; k--) rdy[k] = !v_ff[k] || rdy[k+1];
      en = rdy[NS:1];
      v_in[1] = req_chan.valid;
      for (int k = 2; k <= NS; k++) v_in[k] = v_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) if (en[k]) v_ff[k] <= v_in[k];
      end
   end

   assign req_chan.ready = rdy[1];
   assign rsp_chan.valid = v_ff[NS];

   // Stage 1: saturate and mask the limbs, drop the sign of a zero magnitude.
   dfpa_pkg::limb_type a_raw [NL], b_raw [NL], a1_in [NL], b1_in [NL];
   dfpa_pkg::limb_type a1_ff [NL], b1_ff [NL];
   logic an1_ff, bn1_ff, an1_in, bn1_in;
   dfpa_pkg::kind_type kind1_ff;

   always_comb begin
      a_raw[0] = req_chan.a_limb0; a_raw[1] = req_chan.a_limb1;
      a_raw[2] = req_chan.a_limb2; a_raw[3] = req_chan.a_limb3;
      b_raw[0] = req_chan.b_limb0; b_raw[1] = req_chan.b_limb1;
      b_raw[2] = req_chan.b_limb2; b_raw[3] = req_chan.b_limb3;
      an1_in = 1'b0;
      bn1_in = 1'b0;
      for (int i = 0; i < NL; i++) begin
         a1_in[i] = (i >= LIMBS) ? '0 :
                    (a_raw[i] > dfpa_pkg::LIMB_MAX) ? dfpa_pkg::LIMB_MAX : a_raw[i];
         b1_in[i] = (i >= LIMBS) ? '0 :
                    (b_raw[i] > dfpa_pkg::LIMB_MAX) ? dfpa_pkg::LIMB_MAX : b_raw[i];
         an1_in = an1_in | (a1_in[i] != '0);
         bn1_in = bn1_in | (b1_in[i] != '0);
      end
      an1_in = an1_in & req_chan.a_negative;
      bn1_in = bn1_in & req_chan.b_negative;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         an1_ff   <= an1_in;
         bn1_ff   <= bn1_in;
         kind1_ff <= dfpa_pkg::kind_type'(req_chan.kind);
      end
   end

   // Stage 2: order magnitudes and pick operands and sign for add and subtract.
   dfpa_pkg::ctl_type ctl_ff [2:7], ctl_in [3:7];
   dfpa_pkg::ctl_type ctl2_in;
   dfpa_pkg::limb_type x2_ff [NL], y2_ff [NL], x2_in [NL], y2_in [NL];
   logic add2_ff, add2_in;
   logic gt, lt, bzero, eb;

   always_comb begin
      gt = 1'b0;
      lt = 1'b0;
      bzero = 1'b1;
      for (int i = 0; i < NL; i++) begin
         bzero = bzero & (b1_ff[i] == '0);
         if (a1_ff[i] > b1_ff[i]) begin
            gt = 1'b1;
            lt = 1'b0;
         end else if (a1_ff[i] < b1_ff[i]) begin
            gt = 1'b0;
            lt = 1'b1;
         end
      end
      eb = (kind1_ff == dfpa_pkg::KIND_SUB) ? !bn1_ff && !bzero : bn1_ff;
      add2_in = (an1_ff == eb);
      ctl2_in = '0;
      ctl2_in.kind = kind1_ff;
      x2_in = a1_ff;
      y2_in = b1_ff;
      case (kind1_ff)
         dfpa_pkg::KIND_ADD, dfpa_pkg::KIND_SUB: begin
            ctl2_in.rn = an1_ff;
            if (!add2_in && lt) begin
               x2_in = b1_ff;
               y2_in = a1_ff;
               ctl2_in.rn = eb;
            end
         end
         dfpa_pkg::KIND_MUL: ctl2_in.rn = an1_ff ^ bn1_ff;
         default: begin
            if (an1_ff != bn1_ff)
               ctl2_in.ord = an1_ff ? dfpa_pkg::ORD_LT : dfpa_pkg::ORD_GT;
            else if (gt)
               ctl2_in.ord = an1_ff ? dfpa_pkg::ORD_LT : dfpa_pkg::ORD_GT;
            else if (lt)
               ctl2_in.ord = an1_ff ? dfpa_pkg::ORD_GT : dfpa_pkg::ORD_LT;
            else
               ctl2_in.ord = dfpa_pkg::ORD_EQ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x2_ff   <= x2_in;
         y2_ff   <= y2_in;
         add2_ff <= add2_in;
      end
   end

   // Stage 3: per-limb sum or difference with generate and propagate bits.
   logic [30:0] s3_ff [NL], s3_in [NL];
   logic [NL-1:0] g3_ff, p3_ff, g3_in, p3_in;
   logic add3_ff;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         if (add2_ff) begin
            s3_in[i] = 31'(x2_ff[i]) + 31'(y2_ff[i]);
            g3_in[i] = s3_in[i] >= 31'(dfpa_pkg::BASE);
            p3_in[i] = s3_in[i] == 31'(dfpa_pkg::LIMB_MAX);
         end else begin
            s3_in[i] = 31'(x2_ff[i]) - 31'(y2_ff[i]);
            g3_in[i] = x2_ff[i] < y2_ff[i];
            p3_in[i] = x2_ff[i] == y2_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_ff   <= s3_in;
         g3_ff   <= g3_in;
         p3_ff   <= p3_in;
         add3_ff <= add2_ff;
      end
   end

   // Stage 4: ripple carries or borrows and finish the add/subtract result.
   logic [NL:0] cy;
   logic [30:0] adj;

   always_comb begin
      ctl_in[3] = ctl_ff[2];
      ctl_in[4] = ctl_ff[3];
      ctl_in[5] = ctl_ff[4];
      ctl_in[6] = ctl_ff[5];
      ctl_in[7] = ctl_ff[6];
      cy[0] = 1'b0;
      adj = '0;
      for (int i = 0; i < NL; i++) begin
         cy[i+1] = g3_ff[i] | (p3_ff[i] & cy[i]);
         if (add3_ff)
            adj = s3_ff[i] + 31'(cy[i]) - (cy[i+1] ? 31'(dfpa_pkg::BASE) : 31'd0);
         else
            adj = s3_ff[i] - 31'(cy[i]) + (cy[i+1] ? 31'(dfpa_pkg::BASE) : 31'd0);
         ctl_in[4].asr[i] = (i < LIMBS) ? adj[29:0] : '0;
      end
      ctl_in[4].aovf = add3_ff & cy[LIMBS];
   end

   always_ff @(posedge clock) begin
      if (en[2]) ctl_ff[2] <= ctl2_in;
      for (int k = 3; k <= 7; k++) if (en[k]) ctl_ff[k] <= ctl_in[k];
   end

   // Stages 2 to 5: limb products split into base-1e9 digit pairs.
   dfpa_pkg::limb_type hi [NL][NL], lo [NL][NL];

   for (genvar gi = 0; gi < NL; gi++) begin : g_row
      for (genvar gj = 0; gj < NL; gj++) begin : g_col
         dfpa_prod u_prod (
            .clock (clock),
            .en    (en[5:2]),
            .a     (a1_ff[gi]),
            .b     (b1_ff[gj]),
            .hi    (hi[gi][gj]),
            .lo    (lo[gi][gj])
         );
      end
   end

   // Stage 6: column sums of up to seven digits.
   logic [32:0] col6_ff [NC], col6_in [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         col6_in[c] = '0;
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               if (i + j == c)     col6_in[c] = col6_in[c] + 33'(lo[i][j]);
               if (i + j + 1 == c) col6_in[c] = col6_in[c] + 33'(hi[i][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) col6_ff <= col6_in;
   end

   // Stage 7: split each column sum into a small carry and a digit.
   dfpa_pkg::limb_type r7_ff [NC], r7_in [NC];
   logic [2:0] q7_ff [NC], q7_in [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         q7_in[c] = '0;
         for (int k = 1; k <= 6; k++)
            if (col6_ff[c] >= 33'(k) * 33'(dfpa_pkg::BASE)) q7_in[c] = 3'(k);
         r7_in[c] = 30'(col6_ff[c] - 33'(q7_in[c]) * 33'(dfpa_pkg::BASE));
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         r7_ff <= r7_in;
         q7_ff <= q7_in;
      end
   end

   // Stage 8: final carry ripple across columns, result selection, zero sign.
   logic [30:0] vs [NC];
   logic [NC:0] cc;
   dfpa_pkg::limb_type mcol [NC];
   logic lost, rzero;
   dfpa_pkg::limb_type [NL-1:0] rl;
   logic rn, rovf;
   logic [1:0] rord;
   dfpa_pkg::limb_type [NL-1:0] rl_ff;
   logic rn_ff, rovf_ff;
   logic [1:0] rord_ff;

   always_comb begin
      cc[0] = 1'b0;
      lost = q7_ff[NC-1] != '0;
      for (int c = 0; c < NC; c++) begin
         vs[c] = 31'(r7_ff[c]) + ((c == 0) ? 31'd0 : 31'(q7_ff[(c == 0) ? 0 : c - 1]));
         cc[c+1] = (vs[c] >= 31'(dfpa_pkg::BASE)) |
                   ((vs[c] == 31'(dfpa_pkg::LIMB_MAX)) & cc[c]);
         mcol[c] = 30'(vs[c] + 31'(cc[c]) -
                   (cc[c+1] ? 31'(dfpa_pkg::BASE) : 31'd0));
         if (c >= FRAC_LIMBS + LIMBS && mcol[c] != '0) lost = 1'b1;
      end
      lost = lost | cc[NC];
      rl = ctl_ff[7].asr;
      rovf = ctl_ff[7].aovf;
      rord = dfpa_pkg::ORD_EQ;
      case (ctl_ff[7].kind)
         dfpa_pkg::KIND_ADD, dfpa_pkg::KIND_SUB: ;
         dfpa_pkg::KIND_MUL: begin
            for (int i = 0; i < NL; i++)
               rl[i] = (i < LIMBS && FRAC_LIMBS + i < NC) ?
                       mcol[(FRAC_LIMBS + i) % NC] : '0;
            rovf = lost;
         end
         default: begin
            rl = '0;
            rovf = 1'b0;
            rord = ctl_ff[7].ord;
         end
      endcase
      rzero = 1'b1;
      for (int i = 0; i < NL; i++) rzero = rzero & (rl[i] == '0);
      rn = ctl_ff[7].rn & !rzero;
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         rl_ff   <= rl;
         rn_ff   <= rn;
         rovf_ff <= rovf;
         rord_ff <= rord;
      end
   end

   assign rsp_chan.r_negative = rn_ff;
   assign rsp_chan.r_limb0    = rl_ff[0];
   assign rsp_chan.r_limb1    = rl_ff[1];
   assign rsp_chan.r_limb2    = rl_ff[2];
   assign rsp_chan.r_limb3    = rl_ff[3];
   assign rsp_chan.overflow   = rovf_ff;
   assign rsp_chan.order      = rord_ff;
endmodule
`default_nettype wire

@@ rtl/dfpa_prod.sv @@
// One limb product, split into high and low base-1e9 digits over four stages.
`timescale 1ns / 1ps
`default_nettype none
module dfpa_prod (
   input  wire logic               clock,
   input  wire logic [3:0]         en,
   input  wire dfpa_pkg::limb_type a,
   input  wire dfpa_pkg::limb_type b,
   output dfpa_pkg::limb_type      hi,
   output dfpa_pkg::limb_type      lo
);
   logic [59:0] p2_ff;
   logic [30:0] q3_ff, q4_ff;
   logic [62:0] est;
   logic [31:0] p3_ff, p4_ff, qm4_ff, rem;
   logic [60:0] qm;
   dfpa_pkg::limb_type hi_ff, hi_in, lo_ff, lo_in;

   // The estimate is low by at most two, so the remainder fits in 32 bits.
   assign est = 63'(p2_ff[59:29]) * 63'(dfpa_pkg::RECIP_BASE);
   assign qm  = 61'(q3_ff) * 61'(dfpa_pkg::BASE);
   assign rem = p4_ff - qm4_ff;

   always_comb begin
      if (rem >= 32'd2000000000) begin
         lo_in = 30'(rem - 32'd2000000000);
         hi_in = 30'(q4_ff + 31'd2);
      end else if (rem >= 32'(dfpa_pkg::BASE)) begin
         lo_in = 30'(rem - 32'(dfpa_pkg::BASE));
         hi_in = 30'(q4_ff + 31'd1);
      end else begin
         lo_in = rem[29:0];
         hi_in = q4_ff[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) p2_ff <= 60'(a) * 60'(b);
      if (en[1]) begin
         p3_ff <= p2_ff[31:0];
         q3_ff <= est[62:32];
      end
      if (en[2]) begin
         p4_ff  <= p3_ff;
         q4_ff  <= q3_ff;
         qm4_ff <= qm[31:0];
      end
      if (en[3]) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign hi = hi_ff;
   assign lo = lo_ff;
endmodule
`default_nettype wire

@@ bench/tb_decimal_fixed_point_alu.sv @@
// Self-checking bench for the decimal fixed-point ALU with predicted results.
`timescale 1ns / 1ps
module tb_decimal_fixed_point_alu;
   localparam int NLIMB = dfpa_pkg::DEF_LIMBS;
   localparam int NFRAC = dfpa_pkg::DEF_FRAC_LIMBS;
   localparam longint unsigned DEC_BASE = 64'd1000000000;
   localparam longint unsigned DEC_MAX  = 64'd999999999;

   typedef struct {
      dfpa_pkg::kind_type kind;
      logic               an;
      logic [29:0]        al [4];
      logic               bn;
      logic [29:0]        bl [4];
   } alu_request_type;

   typedef struct {
      logic        rn;
      logic [29:0] rl [4];
      logic        ovf;
      logic [1:0]  ord;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dfpa_req_if req_chan ();
   dfpa_rsp_if rsp_chan ();

   decimal_fixed_point_alu dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   alu_request_type pending_requests [$];
   alu_result_type  expected_results [$];
   int  mismatch_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  kind_count [4] = '{0, 0, 0, 0};
   int  overflow_count = 0;
   bit  stimulus_done = 1'b0;
   bit  calm_mode = 1'b0;
   bit  hold_sender = 1'b0;

   function automatic void load_magnitude(input logic [29:0] l [4],
                                          output longint unsigned m [4]);
      for (int i = 0; i < 4; i++) begin
         longint unsigned v;
         v = 64'(l[i]);
         if (v > DEC_MAX) v = DEC_MAX;
         m[i] = (i < NLIMB) ? v : 64'd0;
      end
   endfunction

   function automatic bit magnitude_zero(input longint unsigned m [4]);
      return m[0] == 0 && m[1] == 0 && m[2] == 0 && m[3] == 0;
   endfunction

   function automatic int compare_magnitude(input longint unsigned x [4],
                                            input longint unsigned y [4]);
      for (int i = 3; i >= 0; i--) begin
         if (x[i] > y[i]) return 1;
         if (x[i] < y[i]) return -1;
      end
      return 0;
   endfunction

   function automatic void subtract_magnitude(input longint unsigned x [4],
                                              input longint unsigned y [4],
                                              output longint unsigned r [4]);
      longint unsigned borrow;
      longint unsigned need;
      borrow = 0;
      r = '{0, 0, 0, 0};
      for (int i = 0; i < NLIMB; i++) begin
         need = y[i] + borrow;
         if (x[i] < need) begin
            r[i] = x[i] + DEC_BASE - need;
            borrow = 1;
         end else begin
            r[i] = x[i] - need;
            borrow = 0;
         end
      end
   endfunction

   function automatic alu_result_type predict_decimal_result(input alu_request_type q);
      longint unsigned a [4];
      longint unsigned b [4];
      longint unsigned r [4];
      longint unsigned col [16];
      longint unsigned carry;
      longint unsigned t;
      alu_result_type res;
      bit an;
      bit bn;
      bit eb;
      bit rn;
      bit ovf;
      int ord;
      load_magnitude(q.al, a);
      load_magnitude(q.bl, b);
      an = q.an && !magnitude_zero(a);
      bn = q.bn && !magnitude_zero(b);
      r = '{0, 0, 0, 0};
      rn = 1'b0;
      ovf = 1'b0;
      ord = 0;
      case (q.kind)
         dfpa_pkg::KIND_ADD, dfpa_pkg::KIND_SUB: begin
            eb = (q.kind == dfpa_pkg::KIND_SUB) ? !bn : bn;
            if (magnitude_zero(b)) eb = 1'b0;
            if (an == eb) begin
               carry = 0;
               for (int i = 0; i < NLIMB; i++) begin
                  t = a[i] + b[i] + carry;
                  if (t > DEC_MAX) begin
                     t -= DEC_BASE;
                     carry = 1;
                  end else begin
                     carry = 0;
                  end
                  r[i] = t;
               end
               ovf = carry != 0;
               rn = an;
            end else if (compare_magnitude(a, b) >= 0) begin
               subtract_magnitude(a, b, r);
               rn = an;
            end else begin
               subtract_magnitude(b, a, r);
               rn = eb;
            end
         end
         dfpa_pkg::KIND_MUL: begin
            for (int i = 0; i < 16; i++) col[i] = 0;
            for (int i = 0; i < NLIMB; i++)
               for (int j = 0; j < NLIMB; j++)
                  col[i + j] += a[i] * b[j];
            carry = 0;
            for (int i = 0; i < 16; i++) begin
               t = col[i] + carry;
               carry = t / DEC_BASE;
               col[i] = t % DEC_BASE;
            end
            for (int i = 0; i < NLIMB; i++) r[i] = col[NFRAC + i];
            for (int i = NFRAC + NLIMB; i < 16; i++) if (col[i] != 0) ovf = 1'b1;
            if (carry != 0) ovf = 1'b1;
            rn = an != bn;
         end
         default: begin
            if (an != bn) ord = an ? -1 : 1;
            else begin
               ord = compare_magnitude(a, b);
               if (an) ord = -ord;
            end
         end
      endcase
      if (magnitude_zero(r)) rn = 1'b0;
      res.rn = rn;
      for (int i = 0; i < 4; i++) res.rl[i] = r[i][29:0];
      res.ovf = ovf;
      res.ord = (ord < 0) ? dfpa_pkg::ORD_LT : (ord > 0 ? dfpa_pkg::ORD_GT : dfpa_pkg::ORD_EQ);
      return res;
   endfunction

   // Mostly valid limbs, sometimes a corner value or an out-of-range pattern.
   function automatic logic [29:0] random_limb();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0: return 30'd0;
         1: return 30'd999999999;
         2: return 30'd1;
         3: return 30'($urandom_range(1000000000, 1073741823));
         4: return 30'($urandom_range(0, 9));
         5: return 30'd999999999 - 30'($urandom_range(0, 9));
         default: return 30'($urandom_range(0, 999999999));
      endcase
   endfunction

   function automatic alu_request_type random_request();
      alu_request_type q;
      int shape;
      q.kind = dfpa_pkg::kind_type'($urandom_range(0, 3));
      q.an = 1'($urandom_range(0, 1));
      q.bn = 1'($urandom_range(0, 1));
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
         q.al[i] = random_limb();
         q.bl[i] = random_limb();
      end
      if (shape == 0) q.bl = q.al;
      else if (shape == 1) begin
         // Operands with few integer limbs keep multiplies inside the format.
         q.al[3] = '0;
         q.bl[3] = '0;
         if ($urandom_range(0, 1) != 0) q.al[2] = '0;
         q.bl[2] = '0;
      end else if (shape == 2) begin
         q.al[3] = '0;
         q.al[2] = '0;
      end else if (shape == 3) begin
         q.bl[0] = q.al[0];
         q.bl[1] = q.al[1];
         q.bl[2] = q.al[2];
      end
      return q;
   endfunction

   function automatic alu_request_type make_request(dfpa_pkg::kind_type k, logic an,
                                                    logic [29:0] av, logic bn,
                                                    logic [29:0] bv, int lane);
      alu_request_type q;
      q.kind = k;
      q.an = an;
      q.bn = bn;
      for (int i = 0; i < 4; i++) begin
         q.al[i] = (lane < 0 || i == lane) ? av : 30'd0;
         q.bl[i] = (lane < 0 || i == lane) ? bv : 30'd0;
      end
      return q;
   endfunction

   initial begin
      for (int k = 0; k < 4; k++) begin
         pending_requests.push_back(make_request(dfpa_pkg::kind_type'(k), 1'b0,
                                                 30'd999999999, 1'b0, 30'd999999999, -1));
         pending_requests.push_back(make_request(dfpa_pkg::kind_type'(k), 1'b1, 30'd0,
                                                 1'b0, 30'd0, -1));
         pending_requests.push_back(make_request(dfpa_pkg::kind_type'(k), 1'b1,
                                                 30'h3FFFFFFF, 1'b1, 30'h3FFFFFFF, -1));
         pending_requests.push_back(make_request(dfpa_pkg::kind_type'(k), 1'b1, 30'd5,
                                                 1'b0, 30'd7, 0));
      end
      pending_requests.push_back(make_request(dfpa_pkg::KIND_SUB, 1'b0, 30'd12345,
                                              1'b0, 30'd12345, 2));
      pending_requests.push_back(make_request(dfpa_pkg::KIND_ADD, 1'b1, 30'd7,
                                              1'b0, 30'd7, 1));
      pending_requests.push_back(make_request(dfpa_pkg::KIND_MUL, 1'b1, 30'd0,
                                              1'b0, 30'd3, -1));
      pending_requests.push_back(make_request(dfpa_pkg::KIND_MUL, 1'b0, 30'd1,
                                              1'b1, 30'd999999999, 2));
      pending_requests.push_back(make_request(dfpa_pkg::KIND_CMP, 1'b1, 30'd0,
                                              1'b0, 30'd0, -1));
      pending_requests.push_back(make_request(dfpa_pkg::KIND_CMP, 1'b1, 30'd4,
                                              1'b1, 30'd9, 3));
      pending_requests.push_back(make_request(dfpa_pkg::KIND_ADD, 1'b0, 30'h2AAAAAAA,
                                              1'b1, 30'h15555555, -1));
      for (int n = 0; n < 900; n++) pending_requests.push_back(random_request());
      wait (pending_requests.size() == 0);
      // Drain the pipeline completely before the second half.
      hold_sender = 1'b1;
      wait (expected_results.size() == 0);
      hold_sender = 1'b0;
      calm_mode = 1'b1;
      for (int n = 0; n < 300; n++) pending_requests.push_back(random_request());
      wait (pending_requests.size() == 0);
      calm_mode = 1'b0;
      for (int n = 0; n < 580; n++) pending_requests.push_back(random_request());
      wait (pending_requests.size() == 0);
      stimulus_done = 1'b1;
   end

   // Request driver. The front item stays queued until its handshake, so the driver
   // peeks at it.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            alu_request_type q;
            q = pending_requests.pop_front();
            expected_results.push_back(predict_decimal_result(q));
            kind_count[q.kind]++;
            sent_count++;
         end
         if (pending_requests.size() != 0 && !hold_sender
             && (calm_mode || $urandom_range(0, 99) >= 33)) begin
            req_chan.valid      <= 1'b1;
            req_chan.kind       <= pending_requests[0].kind;
            req_chan.a_negative <= pending_requests[0].an;
            req_chan.a_limb3    <= pending_requests[0].al[3];
            req_chan.a_limb2    <= pending_requests[0].al[2];
            req_chan.a_limb1    <= pending_requests[0].al[1];
            req_chan.a_limb0    <= pending_requests[0].al[0];
            req_chan.b_negative <= pending_requests[0].bn;
            req_chan.b_limb3    <= pending_requests[0].bl[3];
            req_chan.b_limb2    <= pending_requests[0].bl[2];
            req_chan.b_limb1    <= pending_requests[0].bl[1];
            req_chan.b_limb0    <= pending_requests[0].bl[0];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = dfpa_pkg::KIND_ADD;
      req_chan.a_negative = 1'b0;
      req_chan.a_limb3 = '0;
      req_chan.a_limb2 = '0;
      req_chan.a_limb1 = '0;
      req_chan.a_limb0 = '0;
      req_chan.b_negative = 1'b0;
      req_chan.b_limb3 = '0;
      req_chan.b_limb2 = '0;
      req_chan.b_limb1 = '0;
      req_chan.b_limb0 = '0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            alu_result_type e;
            logic [29:0] got [4];
            bit limbs_differ;
            got[0] = rsp_chan.r_limb0;
            got[1] = rsp_chan.r_limb1;
            got[2] = rsp_chan.r_limb2;
            got[3] = rsp_chan.r_limb3;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response: limbs %0d %0d %0d %0d", got[3], got[2],
                           got[1], got[0]);
            end else begin
               e = expected_results.pop_front();
               checked_count++;
               if (e.ovf) overflow_count++;
               limbs_differ = 1'b0;
               for (int i = 0; i < 4; i++)
                  if (e.rl[i] !== got[i]) limbs_differ = 1'b1;
               if (e.rn !== rsp_chan.r_negative || limbs_differ
                   || e.ovf !== rsp_chan.overflow || e.ord !== rsp_chan.order) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch on response %0d: expected sign %0b limbs %0d %0d %0d %0d ovf %0b ord %0d,",
                              checked_count, e.rn, e.rl[3], e.rl[2], e.rl[1], e.rl[0],
                              e.ovf, e.ord);
                     $display("   got sign %0b limbs %0d %0d %0d %0d ovf %0b ord %0d",
                              rsp_chan.r_negative, got[3], got[2], got[1], got[0],
                              rsp_chan.overflow, rsp_chan.order);
                  end
               end
            end
         end
         rsp_chan.ready <= calm_mode || ($urandom_range(0, 99) >= 33);
      end
   end

   initial begin
      wait (stimulus_done && expected_results.size() == 0);
      repeat (40) @(posedge clock);
      $display("Checked %0d of %0d requests: %0d add, %0d subtract, %0d multiply,",
               checked_count, sent_count, kind_count[0], kind_count[1], kind_count[2]);
      $display("%0d compare; %0d results overflowed, %0d mismatches.", kind_count[3],
               overflow_count, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d responses outstanding.", expected_results.size());
      $display("== FAIL ==");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/dfpa_pkg.sv
rtl/dfpa_ifs.sv
rtl/dfpa_prod.sv
rtl/decimal_fixed_point_alu.sv
bench/tb_decimal_fixed_point_alu.sv
